### hdl/c16ex_pkg.sv
// Shared types and constants for the 16-bit mov/alu/branch execute block.
// Holds the opcode, operand and addressing codes, the item layout on the
// stream ports and the sequencer state type. Depends on nothing.
package c16ex_pkg;

   // Stream port widths
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 6;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   // Result item layout
   localparam int RSP_OFFSET_LSB = 0;
   localparam int RSP_VALUE_LSB  = 8;
   localparam int RSP_ZERO_BIT   = 24;
   localparam int RSP_SIGN_BIT   = 25;
   localparam int RSP_TAKEN_BIT  = 0;
   localparam int RSP_WROTE_BIT  = 1;

   // Register file
   localparam int REG_COUNT = 8;
   localparam int WORD_SIGN = 15;
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_BX = 3'd3;
   localparam reg_idx_type REG_BP = 3'd5;
   localparam reg_idx_type REG_SI = 3'd6;
   localparam reg_idx_type REG_DI = 3'd7;

   typedef enum logic [2:0] {
      OP_MOV = 3'd0,
      OP_ADD = 3'd1,
      OP_SUB = 3'd2,
      OP_CMP = 3'd3,
      OP_JNE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      SRC_IMM = 2'd0,
      SRC_REG = 2'd1,
      SRC_MEM = 2'd2
   } src_kind_type;

   typedef enum logic [3:0] {
      BASE_BX_SI = 4'd0,
      BASE_BX_DI = 4'd1,
      BASE_BP_SI = 4'd2,
      BASE_BP_DI = 4'd3,
      BASE_SI    = 4'd4,
      BASE_DI    = 4'd5,
      BASE_BP    = 4'd6,
      BASE_BX    = 4'd7,
      BASE_NONE  = 4'd8
   } base_type;

   // One decoded instruction
   typedef struct packed {
      op_type        op;
      logic          dest_is_memory;
      reg_idx_type   dest_reg;
      src_kind_type  src_kind;
      reg_idx_type   src_reg;
      logic [15:0]   imm_value;
      base_type      addr_base;
      logic [15:0]   addr_disp;
      logic [7:0]    branch_disp;
   } instr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_QUOT,
      ST_REM,
      ST_AGEN,
      ST_LOAD,
      ST_EXEC,
      ST_STORE
   } state_type;

endpackage

### hdl/c16ex_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
// Depends on nothing.
module c16ex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, write-first on a matching address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cpu16_mov_alu_branch_execute.sv
// Top level of the 16-bit mov/add/sub/cmp/jne execute block.
// Uses c16ex_pkg for codes and item layout, c16ex_ram for the register
// file and the byte-wide data memory.
//
// Usage:
//   req_* carries one decoded instruction per item; rsp_* returns exactly
//   one result item per instruction, in order. Both sides use tvalid/tready.
//   An input buffer takes the next item while the current one executes, and
//   an output register holds a finished result until the receiver takes it.
// Sequence:
//   Register and immediate operands pass ST_ADDR and ST_EXEC. A memory
//   source or destination adds ST_QUOT, ST_REM and ST_AGEN; a memory
//   source also ST_LOAD, a memory destination ST_STORE. The extra states
//   come from reducing the effective address modulo MEM_BYTES
//   (a reciprocal multiply and a correction, three register stages) and
//   from the single byte-wide memory port: a word takes two accesses.
// Reset:
//   Synchronous, active high. Afterwards the block sweeps the data memory
//   and the register file to zero, one byte per cycle over all MEM_BYTES
//   addresses; req_tready stays low until the sweep ends.
// Stalls:
//   When rsp_tready is low the result waits in the output register; the
//   next instruction runs up to its write-back and then holds, and the
//   input buffer still accepts one more item.
module cpu16_mov_alu_branch_execute #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dest_reg[2:0], src_reg[5:3], imm_value[21:6], addr_base[25:22],
   // addr_disp[41:26], branch_disp[49:42], zero fill[55:50]
   input  logic [c16ex_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op[2:0], dest_is_memory[3], src_kind[5:4]
   input  logic [c16ex_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // jump_offset[7:0], dest_value[23:8], zero_out[24], sign_out[25],
   // zero fill[31:26]
   output logic [c16ex_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // jump_taken[0], wrote_memory[1]
   output logic [c16ex_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import c16ex_pkg::*;

   // Address reduction constants
   localparam int AW    = $clog2(MEM_BYTES);
   localparam int OFFS  = MEM_BYTES * ((32768 + MEM_BYTES - 1) / MEM_BYTES);
   localparam int XMAX  = 65535 + 32767 + OFFS;
   localparam int XW    = $clog2(XMAX + 1);
   localparam longint unsigned RECIP = (64'd1 << 32) / MEM_BYTES;
   localparam int RW    = $clog2(RECIP + 1);
   localparam int PW    = XW + RW;
   localparam int QW    = $clog2(XMAX / MEM_BYTES + 2);

   // Sequencer and buffers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   instr_type         req_item, buf_ff, cur_ff;
   logic              buf_valid_ff, buf_valid_in;
   logic              req_fire, load_cur, done;

   // Architectural state held in flops
   logic [15:0]       bx_ff, bp_ff, si_ff, di_ff;
   logic              zf_ff, sf_ff, flag_we;

   // Address pipeline
   logic [15:0]       base_sum;
   logic [XW-1:0]     x_wide;
   logic [XW-1:0]     x_ff, r_ff, mprod;
   logic [PW-1:0]     qprod;
   logic [QW-1:0]     q_ff;
   logic [AW-1:0]     addr_fix, addr0_ff, addr1;
   logic              addr_cap;

   // Operands and result
   logic [15:0]       src_ff, src_val, res;
   logic [7:0]        lo_ff;
   logic              src_cap, lo_cap;
   logic              arith, need_addr, load_src, store, rf_write_req;

   // Memory ports
   logic              rf_we, rf_re;
   reg_idx_type       rf_waddr, rf_raddr;
   logic [15:0]       rf_wdata, rf_rdata;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in, out_free, out_load;
   logic              taken_ff, wrote_ff, zo_ff, so_ff;
   logic [7:0]        offset_ff;
   logic [15:0]       value_ff;

   // Unpack the request item
   always_comb begin
      req_item.op             = op_type'(req_tuser[2:0]);
      req_item.dest_is_memory = req_tuser[3];
      req_item.src_kind       = src_kind_type'(req_tuser[5:4]);
      req_item.dest_reg       = req_tdata[2:0];
      req_item.src_reg        = req_tdata[5:3];
      req_item.imm_value      = req_tdata[21:6];
      req_item.addr_base      = base_type'(req_tdata[25:22]);
      req_item.addr_disp      = req_tdata[41:26];
      req_item.branch_disp    = req_tdata[49:42];
   end

   assign req_tready = !buf_valid_ff && (state_ff != ST_CLEAR);
   assign req_fire   = req_tvalid && req_tready;

   // Register file and data memory
   c16ex_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_regfile (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (rf_re),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   c16ex_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_datamem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Base register combination, 16-bit wrap
   always_comb begin
      case (cur_ff.addr_base)
         BASE_BX_SI: base_sum = bx_ff + si_ff;
         BASE_BX_DI: base_sum = bx_ff + di_ff;
         BASE_BP_SI: base_sum = bp_ff + si_ff;
         BASE_BP_DI: base_sum = bp_ff + di_ff;
         BASE_SI:    base_sum = si_ff;
         BASE_DI:    base_sum = di_ff;
         BASE_BP:    base_sum = bp_ff;
         BASE_BX:    base_sum = bx_ff;
         default:    base_sum = 16'h0000;
      endcase
   end

   // Biased address, always non-negative; bias is a multiple of MEM_BYTES
   assign x_wide = XW'(base_sum)
                 + {{(XW-16){cur_ff.addr_disp[15]}}, cur_ff.addr_disp}
                 + XW'(OFFS);

   // Quotient estimate (low by at most one), remainder, final correction
   assign qprod    = PW'(x_ff) * PW'(RECIP);
   assign mprod    = XW'(q_ff) * XW'(MEM_BYTES);
   assign addr_fix = (r_ff >= XW'(MEM_BYTES)) ? AW'(r_ff - XW'(MEM_BYTES)) : AW'(r_ff);
   assign addr1    = (addr0_ff == AW'(MEM_BYTES - 1)) ? '0 : addr0_ff + AW'(1);

   always_ff @(posedge clock) begin
      x_ff <= x_wide;
      q_ff <= QW'(qprod >> 32);
      r_ff <= x_ff - mprod;
   end

   // Instruction decode
   always_comb begin
      arith     = (cur_ff.op == OP_ADD) || (cur_ff.op == OP_SUB) || (cur_ff.op == OP_CMP);
      load_src  = (arith || (cur_ff.op == OP_MOV)) && (cur_ff.src_kind == SRC_MEM);
      store     = (cur_ff.op == OP_MOV) && cur_ff.dest_is_memory;
      need_addr = load_src || store;
      rf_write_req = ((cur_ff.op == OP_MOV) && !cur_ff.dest_is_memory)
                  || (cur_ff.op == OP_ADD) || (cur_ff.op == OP_SUB);
   end

   // Source operand and result
   always_comb begin
      case (cur_ff.src_kind)
         SRC_REG: src_val = src_ff;
         SRC_MEM: src_val = {mem_rdata, lo_ff};
         default: src_val = cur_ff.imm_value;
      endcase
      case (cur_ff.op)
         OP_MOV:  res = src_val;
         OP_ADD:  res = rf_rdata + src_val;
         OP_SUB:  res = rf_rdata - src_val;
         OP_CMP:  res = rf_rdata - src_val;
         default: res = 16'h0000;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and memory controls
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      done      = 1'b0;
      load_cur  = 1'b0;
      rf_re     = 1'b0;
      rf_raddr  = cur_ff.dest_reg;
      rf_we     = 1'b0;
      rf_waddr  = cur_ff.dest_reg;
      rf_wdata  = res;
      mem_re    = 1'b0;
      mem_raddr = addr_fix;
      mem_we    = 1'b0;
      mem_waddr = addr0_ff;
      mem_wdata = res[7:0];
      out_load  = 1'b0;
      flag_we   = 1'b0;
      src_cap   = 1'b0;
      addr_cap  = 1'b0;
      lo_cap    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep memory and register file to zero
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'h00;
            rf_we     = (clr_ff < AW'(REG_COUNT));
            rf_waddr  = clr_ff[2:0];
            rf_wdata  = 16'h0000;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            done = 1'b1;
         end
         ST_ADDR: begin
            // Source data arrives; fetch the destination register
            rf_re    = 1'b1;
            src_cap  = 1'b1;
            state_in = need_addr ? ST_QUOT : ST_EXEC;
         end
         ST_QUOT: begin
            state_in = ST_REM;
         end
         ST_REM: begin
            state_in = ST_AGEN;
         end
         ST_AGEN: begin
            // Fetch the low byte
            mem_re   = 1'b1;
            addr_cap = 1'b1;
            state_in = load_src ? ST_LOAD : ST_EXEC;
         end
         ST_LOAD: begin
            // Fetch the high byte, keep the low one
            mem_re    = 1'b1;
            mem_raddr = addr1;
            lo_cap    = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            // Write back once the output register can take the result
            if (out_free) begin
               out_load = 1'b1;
               flag_we  = arith;
               rf_we    = rf_write_req;
               if (store) begin
                  mem_we   = 1'b1;
                  state_in = ST_STORE;
               end else begin
                  done = 1'b1;
               end
            end
         end
         ST_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = addr1;
            mem_wdata = value_ff[15:8];
            done      = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Start the next buffered item and fetch its source register
      if (done) begin
         if (buf_valid_ff) begin
            load_cur = 1'b1;
            rf_re    = 1'b1;
            rf_raddr = buf_ff.src_reg;
            state_in = ST_ADDR;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   assign buf_valid_in = req_fire ? 1'b1 : (load_cur ? 1'b0 : buf_valid_ff);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Flags follow the arithmetic results; base-register copies follow the register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         zf_ff <= 1'b0;
         sf_ff <= 1'b0;
         bx_ff <= 16'h0000;
         bp_ff <= 16'h0000;
         si_ff <= 16'h0000;
         di_ff <= 16'h0000;
      end else begin
         if (flag_we) begin
            zf_ff <= (res == 16'h0000);
            sf_ff <= res[WORD_SIGN];
         end
         if (rf_we) begin
            case (rf_waddr)
               REG_BX:  bx_ff <= rf_wdata;
               REG_BP:  bp_ff <= rf_wdata;
               REG_SI:  si_ff <= rf_wdata;
               REG_DI:  di_ff <= rf_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff <= req_item;
      end
      if (load_cur) begin
         cur_ff <= buf_ff;
      end
      if (src_cap) begin
         src_ff <= rf_rdata;
      end
      if (addr_cap) begin
         addr0_ff <= addr_fix;
      end
      if (lo_cap) begin
         lo_ff <= mem_rdata;
      end
      if (out_load) begin
         taken_ff  <= (cur_ff.op == OP_JNE) && !zf_ff;
         offset_ff <= ((cur_ff.op == OP_JNE) && !zf_ff) ? cur_ff.branch_disp : 8'h00;
         value_ff  <= res;
         wrote_ff  <= store;
         zo_ff     <= arith ? (res == 16'h0000) : zf_ff;
         so_ff     <= arith ? res[WORD_SIGN] : sf_ff;
      end
   end

   // Pack the result item
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_OFFSET_LSB +: 8] = offset_ff;
      rsp_tdata[RSP_VALUE_LSB +: 16] = value_ff;
      rsp_tdata[RSP_ZERO_BIT]        = zo_ff;
      rsp_tdata[RSP_SIGN_BIT]        = so_ff;
      rsp_tuser = '0;
      rsp_tuser[RSP_TAKEN_BIT]       = taken_ff;
      rsp_tuser[RSP_WROTE_BIT]       = wrote_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hdl/c16ex_checker.sv
// Port-level checks for the execute block, bound to the top level.
// Depends on c16ex_pkg for the result item layout.
module c16ex_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [c16ex_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [c16ex_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import c16ex_pkg::*;

   logic [2:0] pend_ff, pend_in;
   logic       in_fire, out_fire;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign pend_in  = pend_ff + 3'(in_fire) - 3'(out_fire);

   // Count items accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No input taken right after reset: memory sweep runs first
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("item accepted during memory sweep");

   // Every result answers an accepted item
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != 3'd0))
      else $error("result without an accepted item");

   // A taken jne saw the zero flag clear and reports no memory write
   a_taken_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_TAKEN_BIT] |-> !rsp_tdata[RSP_ZERO_BIT]
         && !rsp_tuser[RSP_WROTE_BIT])
      else $error("taken jump with zero flag set or with a store");

   // Offset is zero unless the jump is taken
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_TAKEN_BIT] |-> (rsp_tdata[RSP_OFFSET_LSB +: 8] == 8'h00))
      else $error("offset reported for a jump not taken");

endmodule

bind cpu16_mov_alu_branch_execute c16ex_checker u_c16ex_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
